// File: design/fbblur_pkg.sv
// Shared constants, types and the per-tap weighting function of the feedback blur.
package fbblur_pkg;

   // Frame geometry.
   localparam int FRAME_WIDTH  = 256;
   localparam int FRAME_HEIGHT = 256;
   localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;

   // Field widths of the request, response and register channels.
   localparam int PIXEL_W    = 32;
   localparam int COORD_W    = 8;
   localparam int HOFF_W     = 8;
   localparam int VOFF_W     = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   // Internal widths derived from the frame geometry.
   localparam int COL_W  = $clog2(FRAME_WIDTH);
   localparam int ROW_W  = $clog2(FRAME_HEIGHT);
   localparam int ADDR_W = $clog2(FRAME_DEPTH);
   // Column before wrap: column + offset + width - 1, at most 509 + width.
   localparam int CX_W   = $clog2(FRAME_WIDTH + 511);
   // Row plus one: row + offset + tap row, at most 260, compared with the height.
   localparam int RYP_W  = $clog2(FRAME_HEIGHT + 262);

   // Operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_HORIZONTAL_OFFSET = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_VERTICAL_OFFSET   = 8'd1;

   // Register reset values.
   localparam logic [HOFF_W-1:0] HOFF_RESET = 8'd3;
   localparam logic [VOFF_W-1:0] VOFF_RESET = 2'd0;

   // Tap position codes within the 3x3 window.
   localparam logic [1:0] TAP_FIRST  = 2'd0;
   localparam logic [1:0] TAP_CENTER = 2'd1;
   localparam logic [1:0] TAP_LAST   = 2'd2;

   // Lane masks that drop the bits shifted across byte boundaries.
   localparam logic [PIXEL_W-1:0] MASK_CORNER = 32'h0F0F0F0F;
   localparam logic [PIXEL_W-1:0] MASK_EDGE   = 32'h1F1F1F1F;
   localparam logic [PIXEL_W-1:0] MASK_CENTER = 32'h3F3F3F3F;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       mem_write;
      logic       reduce_step;
      logic       tap_start;
      logic       tap_issue;
      logic [1:0] tap_dy;
      logic [1:0] tap_dx;
      logic       rsp_load;
   } fbblur_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic col_reduced;
      logic rsp_free;
   } fbblur_status_type;

   // Weights one neighbor: 1/4 at the center, 1/8 at the edges, 1/16 at the corners.
   function automatic logic [PIXEL_W-1:0] tap_term(input logic [PIXEL_W-1:0] pix,
                                                  input logic [1:0] dy,
                                                  input logic [1:0] dx);
      logic mid_row;
      logic mid_col;
      logic [PIXEL_W-1:0] term;
      mid_row = (dy == TAP_CENTER);
      mid_col = (dx == TAP_CENTER);
      if (mid_row && mid_col) begin
         term = (pix >> 2) & MASK_CENTER;
      end else if (mid_row || mid_col) begin
         term = (pix >> 3) & MASK_EDGE;
      end else begin
         term = (pix >> 4) & MASK_CORNER;
      end
      return term;
   endfunction

endpackage

// File: design/fbblur_req_if.sv
// Request channel: pixel writes and blurred-pixel reads.
interface fbblur_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [fbblur_pkg::COORD_W-1:0] column;
   logic [fbblur_pkg::COORD_W-1:0] row;
   logic [fbblur_pkg::PIXEL_W-1:0] pixel_in;

   modport source (output valid, output op, output column, output row, output pixel_in,
                   input ready);
   modport sink (input valid, input op, input column, input row, input pixel_in,
                 output ready);
endinterface

// File: design/fbblur_rsp_if.sv
// Response channel: one blurred pixel for each read request.
interface fbblur_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fbblur_pkg::PIXEL_W-1:0] blurred_pixel;

   modport source (output valid, output blurred_pixel, input ready);
   modport sink (input valid, input blurred_pixel, output ready);
endinterface

// File: design/fbblur_csr_if.sv
// Register write channel: register index and write data.
interface fbblur_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fbblur_pkg::CSR_INDEX_W-1:0] index;
   logic [fbblur_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/fbblur_ctrl.sv
// Controller state machine that sequences writes and the nine-tap read.
module fbblur_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_op,
   output logic                          req_ready,
   input  fbblur_pkg::fbblur_status_type status,
   output fbblur_pkg::fbblur_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_TAPS   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [1:0] dy_ff;
   logic [1:0] dy_in;
   logic [1:0] dx_ff;
   logic [1:0] dx_in;

   // Next state, tap counters and datapath commands.
   always_comb begin
      state_in        = state_ff;
      dy_in           = dy_ff;
      dx_in           = dx_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.tap_dy      = dy_ff;
      cmd.tap_dx      = dx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == fbblur_pkg::OP_READ) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_REDUCE;
               end else begin
                  cmd.mem_write = 1'b1;
               end
            end
         end
         ST_REDUCE: begin
            // Bring the wrapped base column into the frame, one subtraction a cycle.
            if (status.col_reduced) begin
               cmd.tap_start = 1'b1;
               dy_in         = fbblur_pkg::TAP_FIRST;
               dx_in         = fbblur_pkg::TAP_FIRST;
               state_in      = ST_TAPS;
            end else begin
               cmd.reduce_step = 1'b1;
            end
         end
         ST_TAPS: begin
            // One neighbor fetch per cycle, row by row.
            cmd.tap_issue = 1'b1;
            if (dx_ff == fbblur_pkg::TAP_LAST) begin
               dx_in = fbblur_pkg::TAP_FIRST;
               if (dy_ff == fbblur_pkg::TAP_LAST) begin
                  state_in = ST_DRAIN;
               end else begin
                  dy_in = dy_ff + 2'd1;
               end
            end else begin
               dx_in = dx_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            // The last fetched neighbor is accumulated here.
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dy_ff    <= fbblur_pkg::TAP_FIRST;
         dx_ff    <= fbblur_pkg::TAP_FIRST;
      end else begin
         state_ff <= state_in;
         dy_ff    <= dy_in;
         dx_ff    <= dx_in;
      end
   end

endmodule

// File: design/fbblur_dp.sv
// Datapath: offset registers, frame memory, address generation, accumulator, response register.
module fbblur_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  fbblur_pkg::fbblur_cmd_type         cmd,
   output fbblur_pkg::fbblur_status_type      status,
   input  logic [fbblur_pkg::COORD_W-1:0]     req_column,
   input  logic [fbblur_pkg::COORD_W-1:0]     req_row,
   input  logic [fbblur_pkg::PIXEL_W-1:0]     req_pixel_in,
   input  logic                               csr_write,
   input  logic [fbblur_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fbblur_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [fbblur_pkg::PIXEL_W-1:0]     rsp_blurred_pixel
);

   localparam int PIXEL_W = fbblur_pkg::PIXEL_W;
   localparam int COL_W   = fbblur_pkg::COL_W;
   localparam int ROW_W   = fbblur_pkg::ROW_W;
   localparam int ADDR_W  = fbblur_pkg::ADDR_W;
   localparam int CX_W    = fbblur_pkg::CX_W;
   localparam int RYP_W   = fbblur_pkg::RYP_W;

   logic [fbblur_pkg::HOFF_W-1:0] hoff_ff;
   logic [fbblur_pkg::VOFF_W-1:0] voff_ff;

   logic [CX_W-1:0]    cx_ff;
   logic [CX_W-1:0]    cx_in;
   logic [RYP_W-1:0]   cy_ff;
   logic [RYP_W-1:0]   cy_in;
   logic [COL_W-1:0]   rx_ff;
   logic [COL_W-1:0]   rx_in;
   logic [COL_W-1:0]   rx_step;

   logic [RYP_W-1:0]   ry_plus;
   logic [RYP_W-1:0]   ry_minus;
   logic               row_ok;
   logic [ROW_W-1:0]   row_idx;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_inside;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr;

   logic [PIXEL_W-1:0] frame_mem [fbblur_pkg::FRAME_DEPTH];
   logic [PIXEL_W-1:0] rd_ff;

   logic               tap_valid_ff;
   logic               row_ok_ff;
   logic [1:0]         tap_dy_ff;
   logic [1:0]         tap_dx_ff;
   logic [PIXEL_W-1:0] acc_ff;
   logic [PIXEL_W-1:0] acc_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_data_ff;

   // Offset registers, written by the register channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         hoff_ff <= fbblur_pkg::HOFF_RESET;
         voff_ff <= fbblur_pkg::VOFF_RESET;
      end else if (csr_write) begin
         if (csr_index == fbblur_pkg::REG_HORIZONTAL_OFFSET) begin
            hoff_ff <= csr_data[fbblur_pkg::HOFF_W-1:0];
         end else if (csr_index == fbblur_pkg::REG_VERTICAL_OFFSET) begin
            voff_ff <= csr_data[fbblur_pkg::VOFF_W-1:0];
         end
      end
   end

   // Window center: the column is kept one to the left and the row one above.
   assign status.col_reduced = (cx_ff < CX_W'(fbblur_pkg::FRAME_WIDTH));
   assign rx_step = (rx_ff == COL_W'(fbblur_pkg::FRAME_WIDTH - 1)) ? '0 : rx_ff + COL_W'(1);

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      rx_in = rx_ff;
      if (cmd.capture) begin
         cx_in = CX_W'(req_column) + CX_W'(hoff_ff) + CX_W'(fbblur_pkg::FRAME_WIDTH - 1);
         cy_in = RYP_W'(req_row) + RYP_W'(voff_ff);
      end
      if (cmd.reduce_step) begin
         cx_in = cx_ff - CX_W'(fbblur_pkg::FRAME_WIDTH);
      end
      if (cmd.tap_start) begin
         rx_in = cx_ff[COL_W-1:0];
      end else if (cmd.tap_issue) begin
         // Columns wrap within the row; each new row restarts at the base column.
         rx_in = (cmd.tap_dx == fbblur_pkg::TAP_LAST) ? cx_ff[COL_W-1:0] : rx_step;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      rx_ff <= rx_in;
   end

   // Read address of the current tap; rows outside the frame contribute nothing.
   assign ry_plus  = cy_ff + RYP_W'(cmd.tap_dy);
   assign ry_minus = ry_plus - RYP_W'(1);
   assign row_ok   = (ry_plus != '0) && (ry_plus <= RYP_W'(fbblur_pkg::FRAME_HEIGHT));
   assign row_idx  = row_ok ? ry_minus[ROW_W-1:0] : '0;
   assign rd_addr  = ADDR_W'(row_idx) * ADDR_W'(fbblur_pkg::FRAME_WIDTH) + ADDR_W'(rx_ff);

   // Write address; writes outside the frame are dropped.
   assign wr_inside = (32'(req_column) < 32'(fbblur_pkg::FRAME_WIDTH))
                   && (32'(req_row) < 32'(fbblur_pkg::FRAME_HEIGHT));
   assign wr_addr   = ADDR_W'(req_row) * ADDR_W'(fbblur_pkg::FRAME_WIDTH)
                    + ADDR_W'(req_column);
   assign mem_we    = cmd.mem_write && wr_inside;
   assign mem_addr  = mem_we ? wr_addr : rd_addr;

   // Single-port frame memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= req_pixel_in;
      end
      rd_ff <= frame_mem[mem_addr];
   end

   // Tap information is registered alongside the memory read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff <= 1'b0;
      end else begin
         tap_valid_ff <= cmd.tap_issue;
      end
      row_ok_ff <= row_ok;
      tap_dy_ff <= cmd.tap_dy;
      tap_dx_ff <= cmd.tap_dx;
   end

   // Accumulator of the weighted neighbors.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.capture) begin
         acc_in = '0;
      end else if (tap_valid_ff && row_ok_ff) begin
         acc_in = acc_ff + fbblur_pkg::tap_term(rd_ff, tap_dy_ff, tap_dx_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Response register; it frees the request side while a result waits.
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= acc_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_pixel = rsp_data_ff;

endmodule

// File: design/feedback_blur_3x3_shifted.sv
// A write completes in the idle state; writes can be accepted in consecutive cycles.
// A read request keeps the request side busy while it wraps the shifted column, fetches the
// nine neighbors and loads the response, which turns valid at the end; only then is the next
// read accepted. Wrapping takes at most 2 frame-width subtractions for a 256-wide frame.
// The neighbor fetches go through the single frame memory port; the final state repeats
// while an earlier response is unread. Reset sets offsets to 3 and 0, not memory.
module feedback_blur_3x3_shifted (
   input logic          clock,
   input logic          reset,
   fbblur_req_if.sink   req_bus,
   fbblur_rsp_if.source rsp_bus,
   fbblur_csr_if.sink   csr_bus
);

   fbblur_pkg::fbblur_cmd_type    cmd;
   fbblur_pkg::fbblur_status_type status;
   logic                          req_ready;
   logic                          rsp_valid;
   logic [fbblur_pkg::PIXEL_W-1:0] rsp_blurred_pixel;

   // Register writes are always taken.
   assign csr_bus.ready = 1'b1;

   assign req_bus.ready         = req_ready;
   assign rsp_bus.valid         = rsp_valid;
   assign rsp_bus.blurred_pixel = rsp_blurred_pixel;

   // Sequencer.
   fbblur_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Frame memory and arithmetic.
   fbblur_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_column        (req_bus.column),
      .req_row           (req_bus.row),
      .req_pixel_in      (req_bus.pixel_in),
      .csr_write         (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_valid),
      .rsp_blurred_pixel (rsp_blurred_pixel)
   );

endmodule

// File: dv/feedback_blur_3x3_shifted_checker.sv
// Checker that mirrors the frame and offsets and compares every blurred-pixel response.
`timescale 1ns / 1ps
module feedback_blur_3x3_shifted_checker (
   input  logic  clock,
   input  logic  reset,
   fbblur_req_if req_bus,
   fbblur_rsp_if rsp_bus,
   fbblur_csr_if csr_bus,
   output int    mismatch_count,
   output int    reads_in_flight
);

   // One outstanding read: where it was centered and what it must return.
   typedef struct {
      logic [fbblur_pkg::COORD_W-1:0] column;
      logic [fbblur_pkg::COORD_W-1:0] row;
      logic [fbblur_pkg::PIXEL_W-1:0] blurred;
   } blur_expectation_type;

   logic [fbblur_pkg::PIXEL_W-1:0] frame_image [fbblur_pkg::FRAME_DEPTH];
   logic [fbblur_pkg::HOFF_W-1:0]  hoff_shadow;
   logic [fbblur_pkg::VOFF_W-1:0]  voff_shadow;
   blur_expectation_type           pending_blurs [$];

   initial begin
      mismatch_count  = 0;
      reads_in_flight = 0;
   end

   // Weighted 3x3 sum around (cx, cy); columns wrap, rows outside the frame add nothing.
   function automatic logic [fbblur_pkg::PIXEL_W-1:0] blur_window(int unsigned cx,
                                                                  int unsigned cy);
      int unsigned                    lane_shift [3][3];
      int unsigned                    ry;
      int unsigned                    rx;
      logic [fbblur_pkg::PIXEL_W-1:0] pix;
      logic [fbblur_pkg::PIXEL_W-1:0] lane_mask;
      logic [fbblur_pkg::PIXEL_W-1:0] acc;
      lane_shift = '{'{4, 3, 4}, '{3, 2, 3}, '{4, 3, 4}};
      acc = '0;
      for (int dy = 0; dy < 3; dy++) begin
         // ry is one above the sampled row, so row -1 shows up as zero.
         ry = cy + dy;
         if (ry >= 1 && ry <= fbblur_pkg::FRAME_HEIGHT) begin
            for (int dx = 0; dx < 3; dx++) begin
               rx = (cx + dx + fbblur_pkg::FRAME_WIDTH - 1) % fbblur_pkg::FRAME_WIDTH;
               pix = frame_image[(ry - 1) * fbblur_pkg::FRAME_WIDTH + rx];
               // The mask keeps only the bits that stay inside each byte lane.
               lane_mask = {4{8'hFF >> lane_shift[dy][dx]}};
               acc = acc + ((pix >> lane_shift[dy][dx]) & lane_mask);
            end
         end
      end
      return acc;
   endfunction

   always @(posedge clock) begin : watch_channels
      blur_expectation_type oldest;
      blur_expectation_type fresh;
      if (reset) begin
         hoff_shadow = fbblur_pkg::HOFF_RESET;
         voff_shadow = fbblur_pkg::VOFF_RESET;
         pending_blurs.delete();
      end else begin
         // Register writes change the offsets for requests accepted afterwards.
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               fbblur_pkg::REG_HORIZONTAL_OFFSET:
                  hoff_shadow = csr_bus.data[fbblur_pkg::HOFF_W-1:0];
               fbblur_pkg::REG_VERTICAL_OFFSET:
                  voff_shadow = csr_bus.data[fbblur_pkg::VOFF_W-1:0];
               default: ;
            endcase
         end

         // Compare each response with the oldest read still waiting.
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_blurs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: response %h arrived with no read outstanding",
                           $realtime, rsp_bus.blurred_pixel);
               end
            end else begin
               oldest = pending_blurs.pop_front();
               if (rsp_bus.blurred_pixel !== oldest.blurred) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: read at column %0d row %0d: expected %h, got %h",
                              $realtime, oldest.column, oldest.row, oldest.blurred,
                              rsp_bus.blurred_pixel);
                  end
               end
            end
         end

         // Writes update the frame image; reads queue their expected blur.
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.op == fbblur_pkg::OP_WRITE) begin
               frame_image[int'(req_bus.row) * fbblur_pkg::FRAME_WIDTH
                           + int'(req_bus.column)] = req_bus.pixel_in;
            end else begin
               fresh.column  = req_bus.column;
               fresh.row     = req_bus.row;
               fresh.blurred = blur_window(int'(req_bus.column) + int'(hoff_shadow),
                                           int'(req_bus.row) + int'(voff_shadow));
               pending_blurs.push_back(fresh);
            end
         end
      end
      reads_in_flight = pending_blurs.size();
   end

endmodule

// File: dv/feedback_blur_3x3_shifted_tb.sv
// Testbench top for the feedback blur: clock, reset, request and register traffic, verdict.
`timescale 1ns / 1ps
module feedback_blur_3x3_shifted_tb;

   localparam int CYCLE_LIMIT      = 1000000;
   localparam int RANDOM_PER_PHASE = 56;
   localparam int LONG_HOLDOFF     = 400;
   localparam int SETTLE_CYCLES    = 20;

   typedef enum {SINK_ALWAYS, SINK_BUSY, SINK_SPARSE, SINK_TOGGLE} sink_mode_type;

   logic                           clock;
   logic                           reset;
   int                             cycle_count = 0;
   int                             mismatch_count;
   int                             reads_in_flight;
   int                             burst_left;
   int                             items_sent;
   logic                           holdoff_armed;
   logic [fbblur_pkg::COORD_W-1:0] last_column;
   logic [fbblur_pkg::COORD_W-1:0] last_row;
   logic [fbblur_pkg::HOFF_W-1:0]  cur_hoff;
   logic [fbblur_pkg::VOFF_W-1:0]  cur_voff;
   bit                             pixel_written [fbblur_pkg::FRAME_DEPTH];

   fbblur_req_if req_bus();
   fbblur_rsp_if rsp_bus();
   fbblur_csr_if csr_bus();

   feedback_blur_3x3_shifted uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   feedback_blur_3x3_shifted_checker blur_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .mismatch_count  (mismatch_count),
      .reads_in_flight (reads_in_flight)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: ready follows a changing mode, plus one long hold-off when armed.
   initial begin : response_sink
      sink_mode_type mode;
      int            mode_left;
      int            holdoff_left;
      logic          holdoff_used;
      rsp_bus.ready = 1'b0;
      mode = SINK_ALWAYS;
      mode_left = 0;
      holdoff_left = 0;
      holdoff_used = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_armed && !holdoff_used) begin
            holdoff_used = 1'b1;
            holdoff_left = LONG_HOLDOFF;
         end
         if (mode_left == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               SINK_ALWAYS: rsp_bus.ready <= 1'b1;
               SINK_BUSY:   rsp_bus.ready <= ($urandom_range(0, 1) == 0);
               SINK_SPARSE: rsp_bus.ready <= ($urandom_range(0, 6) == 0);
               SINK_TOGGLE: rsp_bus.ready <= ~rsp_bus.ready;
               default:     rsp_bus.ready <= 1'b1;
            endcase
         end
      end
   end

   // Pixel values lean toward all-ones, all-zeros and repeated bytes.
   function automatic logic [fbblur_pkg::PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         2:       return {4{8'($urandom)}};
         default: return $urandom;
      endcase
   endfunction

   // Coordinates lean toward the frame borders where wrapping and clipping happen.
   function automatic logic [fbblur_pkg::COORD_W-1:0] pick_coord();
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return fbblur_pkg::COORD_W'(1);
            2:       return fbblur_pkg::COORD_W'(fbblur_pkg::FRAME_WIDTH - 2);
            default: return '1;
         endcase
      end
      return fbblur_pkg::COORD_W'($urandom);
   endfunction

   // Offer one request in bursts with random gaps, and hold it until accepted.
   task automatic offer_request(input logic op,
                                input logic [fbblur_pkg::COORD_W-1:0] column,
                                input logic [fbblur_pkg::COORD_W-1:0] row,
                                input logic [fbblur_pkg::PIXEL_W-1:0] pixel);
      int   gap;
      logic taken;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
         burst_left = $urandom_range(1, 64);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.column   <= column;
      req_bus.row      <= row;
      req_bus.pixel_in <= pixel;
      // Ready is sampled mid-cycle so the decision does not race the clock edge.
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Write one pixel and note that its entry now holds data.
   task automatic write_pixel(input logic [fbblur_pkg::COORD_W-1:0] column,
                              input logic [fbblur_pkg::COORD_W-1:0] row,
                              input logic [fbblur_pkg::PIXEL_W-1:0] pixel);
      offer_request(fbblur_pkg::OP_WRITE, column, row, pixel);
      pixel_written[int'(row) * fbblur_pkg::FRAME_WIDTH + int'(column)] = 1'b1;
   endtask

   // Read one blurred pixel; neighbors that were never written get a pixel first.
   task automatic read_blur(input logic [fbblur_pkg::COORD_W-1:0] column,
                            input logic [fbblur_pkg::COORD_W-1:0] row);
      int unsigned cx;
      int unsigned cy;
      int unsigned ry;
      int unsigned rx;
      cx = int'(column) + int'(cur_hoff);
      cy = int'(row) + int'(cur_voff);
      for (int dy = 0; dy < 3; dy++) begin
         // ry is one above the sampled row.
         ry = cy + dy;
         if (ry >= 1 && ry <= fbblur_pkg::FRAME_HEIGHT) begin
            for (int dx = 0; dx < 3; dx++) begin
               rx = (cx + dx + fbblur_pkg::FRAME_WIDTH - 1) % fbblur_pkg::FRAME_WIDTH;
               if (!pixel_written[(ry - 1) * fbblur_pkg::FRAME_WIDTH + rx]) begin
                  write_pixel(fbblur_pkg::COORD_W'(rx), fbblur_pkg::COORD_W'(ry - 1),
                              pick_pixel());
               end
            end
         end
      end
      offer_request(fbblur_pkg::OP_READ, column, row, $urandom);
   endtask

   // Stop offering requests and wait until every read has been answered.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (reads_in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both offset registers while the block is idle.
   task automatic set_offsets(input logic [fbblur_pkg::HOFF_W-1:0] hoff,
                              input logic [fbblur_pkg::VOFF_W-1:0] voff);
      logic taken;
      drain_responses();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= fbblur_pkg::REG_HORIZONTAL_OFFSET;
      csr_bus.data  <= fbblur_pkg::CSR_DATA_W'(hoff);
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_bus.ready;
         @(posedge clock);
      end
      csr_bus.index <= fbblur_pkg::REG_VERTICAL_OFFSET;
      csr_bus.data  <= fbblur_pkg::CSR_DATA_W'(voff);
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_bus.ready;
         @(posedge clock);
      end
      csr_bus.valid <= 1'b0;
      cur_hoff = hoff;
      cur_voff = voff;
   endtask

   // Mixed writes and reads; some reads center on the pixel written last.
   task automatic random_traffic(input int count);
      logic [fbblur_pkg::COORD_W-1:0] col;
      logic [fbblur_pkg::COORD_W-1:0] row;
      int                             stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 4) begin
            col = pick_coord();
            row = pick_coord();
            write_pixel(col, row, pick_pixel());
            last_column = col;
            last_row = row;
         end else if ($urandom_range(0, 3) == 0) begin
            read_blur(last_column - cur_hoff, last_row - fbblur_pkg::COORD_W'(cur_voff));
         end else begin
            read_blur(pick_coord(), pick_coord());
         end
      end
   endtask

   initial begin : stimulus
      logic [fbblur_pkg::HOFF_W-1:0] hoff_plan [5];
      logic [fbblur_pkg::VOFF_W-1:0] voff_plan [5];
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.op       = fbblur_pkg::OP_WRITE;
      req_bus.column   = '0;
      req_bus.row      = '0;
      req_bus.pixel_in = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = fbblur_pkg::REG_HORIZONTAL_OFFSET;
      csr_bus.data     = '0;
      holdoff_armed    = 1'b0;
      burst_left       = 0;
      items_sent       = 0;
      last_column      = '0;
      last_row         = '0;
      cur_hoff         = fbblur_pkg::HOFF_RESET;
      cur_voff         = fbblur_pkg::VOFF_RESET;
      hoff_plan = '{fbblur_pkg::HOFF_W'(0), fbblur_pkg::HOFF_W'(254), fbblur_pkg::HOFF_W'(1),
                    fbblur_pkg::HOFF_W'($urandom_range(0, 254)), fbblur_pkg::HOFF_W'(127)};
      voff_plan = '{fbblur_pkg::VOFF_W'(0), fbblur_pkg::VOFF_W'(3), fbblur_pkg::VOFF_W'(1),
                    fbblur_pkg::VOFF_W'($urandom), fbblur_pkg::VOFF_W'(2)};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset offsets (horizontal 3, vertical 0).
      write_pixel(8'd0, 8'd0, '1);
      write_pixel(8'd255, 8'd255, '1);
      write_pixel(8'd255, 8'd0, '0);
      write_pixel(8'd0, 8'd255, 32'h80808080);
      // Top row: the row above the frame adds nothing.
      read_blur(8'd0, 8'd0);
      // Bottom row with the center column wrapping past the right edge.
      read_blur(8'd255, 8'd255);
      // Window straddling the right edge and the first column.
      read_blur(8'd252, 8'd0);
      read_blur(8'd253, 8'd128);
      read_blur(8'd128, 8'd254);
      read_blur(8'd0, 8'd255);
      read_blur(8'd255, 8'd0);
      // Read right after writing the center and one neighbor.
      write_pixel(8'd127, 8'd127, '1);
      write_pixel(8'd128, 8'd127, 32'hFEFEFEFE);
      read_blur(8'd124, 8'd127);
      last_column = 8'd128;
      last_row = 8'd127;
      random_traffic(RANDOM_PER_PHASE);

      // Further offset settings, extremes included; one phase meets a long response stall.
      for (int p = 0; p < 5; p++) begin
         set_offsets(hoff_plan[p], voff_plan[p]);
         if (p == 1) begin
            holdoff_armed <= 1'b1;
         end
         random_traffic(RANDOM_PER_PHASE);
      end

      drain_responses();
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
